// ===== rtl/core/bounded_list_insert_erase_assert.svh =====
// Assertion helpers for the bounded list block.
`ifndef BOUNDED_LIST_INSERT_ERASE_ASSERT_SVH
`define BOUNDED_LIST_INSERT_ERASE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on a given clock, disabled while reset is asserted.
`define BLIE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the standard clk_i / rst_ni pair.
`define BLIE_ASSERT(lbl, prop, msg) \
  `BLIE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define BLIE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define BLIE_ASSERT(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/blie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blie_pkg;

  localparam int unsigned DataW = 32;

  // Operation codes carried by a transaction
  typedef enum logic [2:0] {
    FN_APPEND  = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_INSERT  = 3'd2,
    FN_ERASE   = 3'd3,
    FN_REVERSE = 3'd4,
    FN_CLEAR   = 3'd5,
    FN_LIST    = 3'd6
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_NONE = 2'd3
  } status_e;

  // Per-cycle command broadcast along the cell chain
  typedef enum logic [2:0] {
    CO_HOLD,
    CO_WRITE,
    CO_INSERT,
    CO_ERASE,
    CO_ROTATE
  } cell_op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_REV,
    SQ_LIST
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_list_insert_erase.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bounded_list_insert_erase_assert.svh"

// Bounded ordered list of up to DEPTH signed 32-bit values.
// A transaction is taken on a rising edge with start_i high and busy_o low;
// func_i selects append, remove last, insert, erase, reverse, clear or list.
// Every result is shown for exactly one cycle with done_o high; last_o marks
// the final result of a transaction. count_out_o and empty_flag_o give the
// list size after the operation.
// Timing: results are registered at the accepting edge. Append, remove,
// insert, erase and clear leave busy_o low, so a new transaction can be
// taken every cycle. Reverse of n values rotates the cell chain n-1 times,
// one rotation per cycle, with busy_o high until the last rotation. List
// of n values shifts the chain once per emitted value: n results, one per
// cycle, with busy_o dropping as the final result is shown.
// Reset empties the list at once; stored values need no clearing.
// The receiver cannot stall: results must be taken when done_o is high.
module bounded_list_insert_erase import blie_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [2:0]       func_i,
  input  wire logic [CntW-1:0]  position_i,
  input  wire logic [DataW-1:0] item_value_i,
  output logic                  done_o,
  output logic      [DataW-1:0] element_out_o,
  output logic                  last_o,
  output logic      [CntW-1:0]  count_out_o,
  output logic                  empty_flag_o,
  output logic      [1:0]       status_o
);

  localparam logic [CntW-1:0] Full = CntW'(DEPTH);
  localparam logic [CntW-1:0] One  = CntW'(1);
  localparam logic [CntW-1:0] Two  = CntW'(2);

  state_e           state_d, state_q;
  logic [CntW-1:0]  count_d, count_q;
  logic [CntW-1:0]  step_d, step_q;
  logic             done_d, done_q;
  logic [DataW-1:0] elem_d, elem_q;
  logic             last_d, last_q;
  status_e          status_d, status_q;

  cell_op_e         cop;
  logic [CntW-1:0]  cpos, cbound;
  logic             accept;

  logic [DataW-1:0] cell_data [DEPTH];
  logic [DataW-1:0] left_w    [DEPTH];
  logic [DataW-1:0] right_w   [DEPTH];

  assign busy_o = (state_q != SQ_IDLE);
  assign accept = start_i && !busy_o;

  // Cell chain with neighbor links
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = cell_data[g];
    end else begin : g_mid
      assign left_w[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w[g] = cell_data[g];
    end else begin : g_inner
      assign right_w[g] = cell_data[g+1];
    end

    blie_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cop),
      .pos_i   (cpos),
      .bound_i (cbound),
      .value_i (item_value_i),
      .left_i  (left_w[g]),
      .right_i (right_w[g]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  // Sequencer: decode, bounds checks, multi-cycle reverse and list
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    step_d   = step_q;
    done_d   = 1'b0;
    elem_d   = '0;
    last_d   = 1'b1;
    status_d = ST_OK;
    cop      = CO_HOLD;
    cpos     = position_i;
    cbound   = count_q;

    case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (func_e'(func_i))
            FN_APPEND: begin
              if (count_q == Full) begin
                status_d = ST_FULL;
              end else begin
                cop     = CO_WRITE;
                cpos    = count_q;
                count_d = count_q + One;
              end
            end
            FN_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_BAD;
              end else begin
                count_d = count_q - One;
              end
            end
            FN_INSERT: begin
              if (count_q == Full) begin
                status_d = ST_FULL;
              end else if (position_i > count_q) begin
                status_d = ST_BAD;
              end else begin
                cop     = CO_INSERT;
                count_d = count_q + One;
              end
            end
            FN_ERASE: begin
              if (position_i >= count_q) begin
                status_d = ST_BAD;
              end else begin
                cop     = CO_ERASE;
                count_d = count_q - One;
              end
            end
            FN_REVERSE: begin
              if (count_q >= Two) begin
                cop = CO_ROTATE;
                if (count_q > Two) begin
                  state_d = SQ_REV;
                  step_d  = count_q - One;
                end
              end
            end
            FN_CLEAR: count_d = '0;
            FN_LIST: begin
              if (count_q == '0) begin
                status_d = ST_NONE;
              end else begin
                elem_d = cell_data[0];
                last_d = (count_q == One);
                cop    = CO_ROTATE;
                if (count_q > One) begin
                  state_d = SQ_LIST;
                  step_d  = count_q - One;
                end
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      SQ_REV: begin
        // Rotate the shrinking prefix; head lands at its end
        cop    = CO_ROTATE;
        cbound = step_q;
        step_d = step_q - One;
        if (step_q == Two) state_d = SQ_IDLE;
      end
      SQ_LIST: begin
        // Emit head and rotate the whole list
        done_d = 1'b1;
        elem_d = cell_data[0];
        last_d = (step_q == One);
        cop    = CO_ROTATE;
        step_d = step_q - One;
        if (step_q == One) state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      count_q <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    elem_q   <= elem_d;
    last_q   <= last_d;
    status_q <= status_d;
  end

  assign done_o        = done_q;
  assign element_out_o = elem_q;
  assign last_o        = last_q;
  assign count_out_o   = count_q;
  assign empty_flag_o  = (count_q == '0);
  assign status_o      = status_q;

  // Checks
  `BLIE_ASSERT(a_count_bound, count_q <= Full, "list count above capacity")
  `BLIE_ASSERT(a_more_pending, (done_q && !last_q) |-> busy_o,
               "non-final result but sequencer idle")
  `BLIE_ASSERT(a_list_emits, (state_q == SQ_LIST) |=> done_q,
               "list step produced no result")
  `BLIE_ASSERT(a_rev_size, (state_q == SQ_REV) |-> (count_q > Two),
               "reverse running on a short list")

endmodule

`default_nettype wire

// ===== rtl/core/blie_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One storage slot of the list; picks its next value from the broadcast
// command and its two neighbors.
module blie_cell import blie_pkg::*; #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  wire logic             clk_i,
  input  wire cell_op_e         op_i,
  input  wire logic [CntW-1:0]  pos_i,
  input  wire logic [CntW-1:0]  bound_i,
  input  wire logic [DataW-1:0] value_i,
  input  wire logic [DataW-1:0] left_i,
  input  wire logic [DataW-1:0] right_i,
  input  wire logic [DataW-1:0] head_i,
  output logic      [DataW-1:0] data_o
);

  localparam logic [CntW-1:0] IdxC  = CntW'(Idx);
  localparam logic [CntW-1:0] IdxP1 = CntW'(Idx + 1);

  logic [DataW-1:0] data_d, data_q;

  // Next-value select
  always_comb begin
    data_d = data_q;
    case (op_i)
      CO_HOLD: data_d = data_q;
      CO_WRITE: begin
        if (IdxC == pos_i) data_d = value_i;
      end
      CO_INSERT: begin
        if (IdxC == pos_i) begin
          data_d = value_i;
        end else if (IdxC > pos_i && IdxC <= bound_i) begin
          data_d = left_i;
        end
      end
      CO_ERASE: begin
        if (IdxC >= pos_i && IdxP1 < bound_i) data_d = right_i;
      end
      CO_ROTATE: begin
        if (IdxP1 < bound_i) begin
          data_d = right_i;
        end else if (IdxP1 == bound_i) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Storage, no reset: contents are defined once written
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire
